// ===== src/dqsa_pkg.sv =====
// Package: shared field widths, operation codes and status codes of the deque unit.
`default_nettype none

package dqsa_pkg;

  // Field widths of the channels
  localparam int unsigned DATA_W = 32;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned CNT_W  = 9;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_BACK  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SEARCH    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY     = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd3;

endpackage

`default_nettype wire

// ===== src/dqsa_if.sv =====
// Interfaces: request and response channels of the deque unit.
`default_nettype none

interface dqsa_req_if import dqsa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface dqsa_rsp_if import dqsa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [POS_W-1:0]         position;
  logic [CNT_W-1:0]         count;
  logic signed [DATA_W-1:0] mean;

  modport source (output valid, status, position, count, mean, input ready);
  modport sink   (input valid, status, position, count, mean, output ready);
endinterface

`default_nettype wire

// ===== src/dqsa_div.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module dqsa_div import dqsa_pkg::*; #(
  parameter int unsigned SW = 41,
  parameter int unsigned CW = 9
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [SW-1:0]       dividend,
  input  wire logic [CW-1:0]       divisor,
  output logic                     busy,
  output logic [DATA_W-1:0]        quotient
);

  localparam int unsigned IW = $clog2(SW + 1);

  logic [SW-1:0] quo;
  logic [CW-1:0] rem;
  logic [CW-1:0] dvs;
  logic          neg;
  logic [IW-1:0] iter;

  logic [CW:0]   rem_sh;
  logic          bit_set;
  logic [SW-1:0] quo_fix;

  // One restoring step
  always_comb begin
    rem_sh  = {rem, quo[SW-1]};
    bit_set = rem_sh >= {1'b0, dvs};
  end

  // Sign restored on the way out; with a nonzero divisor the mean's magnitude fits the result field
  assign quo_fix  = neg ? (~quo + SW'(1)) : quo;
  assign quotient = quo_fix[DATA_W-1:0];

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= IW'(SW);
    end else if (busy) begin
      iter <= iter - IW'(1);
      if (iter == IW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SW-1];
      quo <= dividend[SW-1] ? (~dividend + SW'(1)) : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[SW-2:0], bit_set};
      rem <= bit_set ? CW'(rem_sh - {1'b0, dvs}) : rem_sh[CW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/deque_with_search_and_average_unit.sv =====
// Top level: bounded double-ended queue with linear search and running mean.
//
// One request channel (req) carries an operation code and a value; one response channel
// (rsp) returns status, match position, element count and the mean of the held values.
// Every request transaction yields exactly one response transaction, in order.
// Entries sit in a single ring RAM of DEPTH words with a registered read.
// Requests are handled one at a time; req.ready is high only while the unit is waiting,
// so the next request is taken at the earliest in the cycle after a response is loaded.
// The mean comes from the bit-serial divider, started once per request: at once for a
// query, a spare code or a refused push or pop; after count and sum are updated for a
// push; after the popped word is read and they are updated for a pop. A search reads
// one RAM word per cycle, and the divider runs alongside the scan; the default DEPTH is 256.
// Reset clears head pointer, count, running sum and the response valid flag; the RAM is
// not cleared, as only held entries are ever read.
// A finished response waits in the output register; the next request is taken meanwhile,
// and its own response is held back until the previous one has been taken.
`default_nettype none

module deque_with_search_and_average_unit import dqsa_pkg::*; #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic   clk,
  input  wire logic   rst,
  dqsa_req_if.sink    req,
  dqsa_rsp_if.source  rsp
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = DATA_W + CW;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_READ   = 6'b000010,
    ST_START  = 6'b000100,
    ST_SEARCH = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t            state;
  logic [KIND_W-1:0] kind_r;
  logic [DATA_W-1:0] value_r;
  logic [AW-1:0]     head;
  logic [CW-1:0]     occ;
  logic [SW-1:0]     sum;

  // Search scan
  logic [CW-1:0]     srch_cnt;
  logic [AW-1:0]     srch_addr;
  logic              cmp_valid;
  logic [CW-1:0]     cmp_idx;
  logic              hit;

  // Result held until the output register is free
  logic [STAT_W-1:0] res_status;
  logic [POS_W-1:0]  res_position;

  // Output register
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [POS_W-1:0]  out_position;
  logic [CNT_W-1:0]  out_count;
  logic [DATA_W-1:0] out_mean;

  // Ring RAM
  logic [DATA_W-1:0] mem [DEPTH];
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rdata;
  logic              wr_en;

  // Divider
  logic              div_start;
  logic              div_busy;
  logic [DATA_W-1:0] div_quo;

  logic              accept;
  logic              full;
  logic              out_free;
  logic [CW:0]       tail_sum;
  logic [AW-1:0]     tail_addr;
  logic [CW:0]       last_sum;
  logic [AW-1:0]     last_addr;
  logic [AW-1:0]     head_inc;
  logic [AW-1:0]     srch_inc;
  logic [SW-1:0]     rdata_ext;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign full      = (occ == CW'(DEPTH));
  assign out_free  = !out_valid || rsp.ready;

  // Ring address arithmetic, modulo DEPTH
  always_comb begin
    tail_sum  = {1'b0, CW'(head)} + {1'b0, occ};
    tail_addr = (tail_sum >= (CW+1)'(DEPTH)) ? AW'(tail_sum - (CW+1)'(DEPTH))
                                              : AW'(tail_sum);
    last_sum  = {1'b0, CW'(head)} + {1'b0, occ} - (CW+1)'(1);
    last_addr = (last_sum >= (CW+1)'(DEPTH)) ? AW'(last_sum - (CW+1)'(DEPTH))
                                              : AW'(last_sum);
    head_inc  = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
    srch_inc  = (srch_addr == AW'(DEPTH - 1)) ? '0 : srch_addr + AW'(1);
  end

  assign rdata_ext = {{(SW-DATA_W){rdata[DATA_W-1]}}, rdata};
  assign hit       = cmp_valid && (rdata == value_r);

  // RAM port control and divider launch
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = srch_addr;
    wr_en     = 1'b0;
    div_start = 1'b0;
    unique case (state) inside
      ST_IDLE: begin
        if (accept) begin
          case (req.kind)
            KIND_PUSH_BACK: begin
              if (!full) wr_en = 1'b1;
              else       div_start = 1'b1;
            end
            KIND_POP_FRONT: begin
              if (occ != '0) begin
                rd_en   = 1'b1;
                rd_addr = head;
              end else begin
                div_start = 1'b1;
              end
            end
            KIND_POP_BACK: begin
              if (occ != '0) begin
                rd_en   = 1'b1;
                rd_addr = last_addr;
              end else begin
                div_start = 1'b1;
              end
            end
            default: div_start = 1'b1;
          endcase
        end
      end
      ST_START:  div_start = 1'b1;
      ST_SEARCH: rd_en = (srch_cnt != occ);
      ST_READ, ST_DIV, ST_DONE: ;
      default: ;
    endcase
  end

  // Only one request is in flight, so a write never meets a read of the same word
  always_ff @(posedge clk) begin
    if (wr_en) mem[tail_addr] <= req.value;
    if (rd_en) rdata <= mem[rd_addr];
  end

  // Sequencer and queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      occ       <= '0;
      sum       <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Response register: set when loaded, cleared once taken
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            res_position <= '0;
            case (req.kind) inside
              KIND_PUSH_BACK: begin
                if (!full) begin
                  occ        <= occ + CW'(1);
                  sum        <= sum + {{(SW-DATA_W){req.value[DATA_W-1]}}, req.value};
                  res_status <= STATUS_OK;
                  state      <= ST_START;
                end else begin
                  res_status <= STATUS_FULL;
                  state      <= ST_DIV;
                end
              end
              KIND_POP_FRONT, KIND_POP_BACK: begin
                if (occ != '0) begin
                  res_status <= STATUS_OK;
                  state      <= ST_READ;
                end else begin
                  res_status <= STATUS_EMPTY;
                  state      <= ST_DIV;
                end
              end
              KIND_SEARCH: begin
                srch_cnt  <= '0;
                srch_addr <= head;
                cmp_valid <= 1'b0;
                if (occ == '0) begin
                  res_status <= STATUS_NOT_FOUND;
                  state      <= ST_DIV;
                end else begin
                  res_status <= STATUS_OK;
                  state      <= ST_SEARCH;
                end
              end
              default: begin
                res_status <= STATUS_OK;
                state      <= ST_DIV;
              end
            endcase
          end
        end
        ST_READ: begin
          // Popped word is back from the RAM
          sum <= sum - rdata_ext;
          occ <= occ - CW'(1);
          if (kind_r == KIND_POP_FRONT) head <= head_inc;
          state <= ST_START;
        end
        ST_START: state <= ST_DIV;
        ST_SEARCH: begin
          if (srch_cnt != occ) begin
            srch_cnt  <= srch_cnt + CW'(1);
            srch_addr <= srch_inc;
          end
          cmp_idx <= srch_cnt;
          if (hit) begin
            res_position <= POS_W'(cmp_idx);
            cmp_valid    <= 1'b0;
            state        <= ST_DIV;
          end else if (cmp_valid && (cmp_idx == occ - CW'(1))) begin
            res_status <= STATUS_NOT_FOUND;
            cmp_valid  <= 1'b0;
            state      <= ST_DIV;
          end else begin
            cmp_valid <= (srch_cnt != occ);
          end
        end
        ST_DIV: begin
          if (!div_busy) state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Request capture and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= req.kind;
      value_r <= req.value;
    end
    if (state == ST_DONE && out_free) begin
      out_status   <= res_status;
      out_position <= res_position;
      out_count    <= CNT_W'(occ);
      out_mean     <= (occ == '0) ? '0 : div_quo;
    end
  end

  dqsa_div #(
    .SW (SW),
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (occ),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.position = out_position;
  assign rsp.count    = out_count;
  assign rsp.mean     = out_mean;

  // Checks
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (accept && req.kind == KIND_PUSH_BACK && !full) |=> (occ == $past(occ) + CW'(1)))
    else $error("accepted push did not grow the queue");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH && hit) |-> (cmp_idx < occ))
    else $error("search matched outside the held entries");

  a_div_settled: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> !div_busy)
    else $error("result loaded while the divider is busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |=> (out_valid && $stable(out_mean) && $stable(out_count)))
    else $error("waiting response overwritten");

endmodule

`default_nettype wire
